### hdl/ibs_pkg.sv
// ----------------------------------------------------------------------------
// ibs_pkg
// shared types and constants of the integer byte serializer
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] VARINT_CONT = 8'h80;
  localparam logic [7:0] VARINT_MASK = 8'h7f;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_HALF   = 3'd1,
    KIND_WORD   = 3'd2,
    KIND_DWORD  = 3'd3,
    KIND_VARINT = 3'd4,
    KIND_ZIGZAG = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_LE  = 2'd0,
    MODE_BE  = 2'd1,
    MODE_VAR = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  cnt;
    logic [63:0] data;
  } entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

  typedef struct packed {
    logic pop;
    logic avail;
  } qrd_t;

endpackage

### hdl/ibs_front.sv
// ----------------------------------------------------------------------------
// ibs_front
// accepts input items, classifies them and stages one entry for the queue
// ----------------------------------------------------------------------------
module ibs_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      in_kind,
  input  logic [63:0]     in_value,
  input  logic            in_big_endian,
  output ibs_pkg::entry_t q_entry,
  output logic            q_push,
  input  logic            q_full
);
  import ibs_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  entry_t cls;
  logic   known;
  logic   accept;
  logic   push;
  logic [63:0] zz;

  assign zz = {in_value[62:0], 1'b0} ^ {64{in_value[63]}};

  always_comb begin
    cls.mode = MODE_LE;
    cls.cnt  = 3'd0;
    cls.data = in_value;
    known    = 1'b1;
    case (in_kind)
      KIND_BYTE: begin
        cls.mode = MODE_LE;
        cls.cnt  = 3'd0;
      end
      KIND_HALF: begin
        cls.mode = in_big_endian ? MODE_BE : MODE_LE;
        cls.cnt  = 3'd1;
        cls.data = in_big_endian ? {in_value[15:0], 48'd0} : in_value;
      end
      KIND_WORD: begin
        cls.mode = in_big_endian ? MODE_BE : MODE_LE;
        cls.cnt  = 3'd3;
        cls.data = in_big_endian ? {in_value[31:0], 32'd0} : in_value;
      end
      KIND_DWORD: begin
        cls.mode = in_big_endian ? MODE_BE : MODE_LE;
        cls.cnt  = 3'd7;
      end
      KIND_VARINT: begin
        cls.mode = MODE_VAR;
      end
      KIND_ZIGZAG: begin
        cls.mode = MODE_VAR;
        cls.data = zz;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push     = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r && !push;
    entry_nxt = entry_r;
    if (accept && known) begin
      valid_nxt = 1'b1;
      entry_nxt = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q_entry = entry_r;
  assign q_push  = push;

endmodule

### hdl/ibs_queue.sv
// ----------------------------------------------------------------------------
// ibs_queue
// short fifo of classified entries between front and back
// ----------------------------------------------------------------------------
module ibs_queue #(
  parameter int unsigned DEPTH = ibs_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ibs_pkg::entry_t wr_entry,
  input  logic            wr_push,
  output logic            wr_full,
  output ibs_pkg::entry_t rd_entry,
  input  logic            rd_pop,
  output logic            rd_avail
);
  import ibs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign wr_full  = (count_r == FULL_CNT);
  assign rd_avail = (count_r != '0);
  assign do_push  = wr_push && !wr_full;
  assign do_pop   = rd_pop && rd_avail;
  assign rd_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_push && wr_full))
    else $error("push into full queue");

endmodule

### hdl/ibs_back.sv
// ----------------------------------------------------------------------------
// ibs_back
// emits the bytes of one entry per item into an output register, one byte a cycle unless out_stall holds it
// ----------------------------------------------------------------------------
module ibs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ibs_pkg::entry_t q_entry,
  input  logic            q_avail,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import ibs_pkg::*;

  logic        act_valid_r, act_valid_nxt;
  mode_t       mode_r, mode_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [63:0] data_r, data_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;

  logic        adv;
  logic        pop;
  logic [7:0]  cur_byte;
  logic        cur_last;
  logic [63:0] cur_rest;

  always_comb begin
    case (mode_r)
      MODE_BE: begin
        cur_byte = data_r[63:56];
        cur_last = (cnt_r == 3'd0);
        cur_rest = {data_r[55:0], 8'd0};
      end
      MODE_VAR: begin
        cur_last = (data_r[63:7] == '0);
        cur_byte = (data_r[7:0] & VARINT_MASK) | (cur_last ? 8'd0 : VARINT_CONT);
        cur_rest = {7'd0, data_r[63:7]};
      end
      default: begin
        cur_byte = data_r[7:0];
        cur_last = (cnt_r == 3'd0);
        cur_rest = {8'd0, data_r[63:8]};
      end
    endcase
  end

  assign adv = act_valid_r && (!ov_r || !out_stall);
  assign pop = q_avail && (!act_valid_r || (adv && cur_last));

  always_comb begin
    act_valid_nxt = act_valid_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    data_nxt      = data_r;
    ov_nxt        = ov_r && out_stall;
    ob_nxt        = ob_r;
    ol_nxt        = ol_r;
    if (adv) begin
      ov_nxt   = 1'b1;
      ob_nxt   = cur_byte;
      ol_nxt   = cur_last;
      cnt_nxt  = cnt_r - 3'd1;
      data_nxt = cur_rest;
      if (cur_last) begin
        act_valid_nxt = 1'b0;
      end
    end
    if (pop) begin
      act_valid_nxt = 1'b1;
      mode_nxt      = q_entry.mode;
      cnt_nxt       = q_entry.cnt;
      data_nxt      = q_entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      act_valid_r <= act_valid_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    cnt_r  <= cnt_nxt;
    data_r <= data_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

  assign q_pop     = pop;
  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

  a_item_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_stall && !ol_r) |=> (ov_r || act_valid_r))
    else $error("item ended without last byte");

  a_var_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mode_r == MODE_VAR) |=> (ob_r[7] == !ol_r))
    else $error("varint continuation bit disagrees with last");

endmodule

### hdl/integer_byte_serializer.sv
// ----------------------------------------------------------------------------
// integer_byte_serializer
// serializes a 64-bit value as fixed-width bytes or an leb128 / zigzag varint
// ----------------------------------------------------------------------------
//  channel  ports                                        direction
//  in       in_valid in_stall in_kind in_value           input item
//           in_big_endian
//  out      out_valid out_stall out_byte out_last        output byte stream
//
//  an item is taken and staged by the front, then queued
//  the back emits one byte per cycle from its output register unless out_stall
//  holds it, so an item gives 1, 2, 4, 8 or 1 to 10 bytes of output
//  items of kind six or seven are taken and give no bytes
//  reset is synchronous and clears the staging, queue and output valids
//  out_stall holds the byte; the queue of QUEUE_DEPTH entries lets input
//  continue until it fills
// ----------------------------------------------------------------------------
module integer_byte_serializer #(
  parameter int unsigned QUEUE_DEPTH = ibs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_value,
  input  logic        in_big_endian,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import ibs_pkg::*;

  entry_t wr_entry;
  entry_t rd_entry;
  qwr_t   qwr;
  qrd_t   qrd;

  ibs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .in_big_endian (in_big_endian),
    .q_entry       (wr_entry),
    .q_push        (qwr.push),
    .q_full        (qwr.full)
  );

  ibs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_entry (wr_entry),
    .wr_push  (qwr.push),
    .wr_full  (qwr.full),
    .rd_entry (rd_entry),
    .rd_pop   (qrd.pop),
    .rd_avail (qrd.avail)
  );

  ibs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_entry   (rd_entry),
    .q_avail   (qrd.avail),
    .q_pop     (qrd.pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
